FILE: src/pva_pkg.sv
package pva_pkg;

   // Port field widths.
   localparam int RADIUS_W = 16;
   localparam int ANGLE_W  = 16;
   localparam int RSUM_W   = 17;

   // Fixed-point layout of the datapath.
   localparam int GUARD_BITS     = 8;
   localparam int INT_ANGLE_BITS = 30;
   localparam int GAIN_W         = 30;
   localparam int ATAN_W         = 32;
   localparam int ATAN_ENTRIES   = 24;

   // Rotation coordinates, summed and vectoring coordinates, vectoring angle.
   localparam int RW   = 26;
   localparam int VW   = 28;
   localparam int ZV_W = 35;

   // Angle constants in Q.30 radians and the inverse CORDIC gain in Q0.30.
   localparam logic [ATAN_W-1:0] PI_Q30      = 32'd3373259426;
   localparam logic [ATAN_W-1:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [GAIN_W-1:0] GAIN_Q30    = 30'd652032874;

   // Arctangent of 2^-i in Q.30, truncated.
   localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

endpackage

FILE: src/pva_req_if.sv
interface pva_req_if;
   logic                                valid;
   logic                                ready;
   logic        [pva_pkg::RADIUS_W-1:0] radius_a;
   logic signed [pva_pkg::ANGLE_W-1:0]  angle_a;
   logic        [pva_pkg::RADIUS_W-1:0] radius_b;
   logic signed [pva_pkg::ANGLE_W-1:0]  angle_b;

   modport source (output valid, radius_a, angle_a, radius_b, angle_b, input ready);
   modport sink   (input valid, radius_a, angle_a, radius_b, angle_b, output ready);
endinterface

FILE: src/pva_rsp_if.sv
interface pva_rsp_if;
   logic                              valid;
   logic                              ready;
   logic        [pva_pkg::RSUM_W-1:0] radius_sum;
   logic signed [pva_pkg::ANGLE_W-1:0] angle_sum;

   modport source (output valid, radius_sum, angle_sum, input ready);
   modport sink   (input valid, radius_sum, angle_sum, output ready);
endinterface

FILE: src/pva_cordic_stage.sv
module pva_cordic_stage #(
   parameter int STEP   = 0,
   parameter int CW     = 26,
   parameter int ZW     = 35,
   parameter bit VECTOR = 1'b0
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic signed [CW-1:0] x_up,
   input  logic signed [CW-1:0] y_up,
   input  logic signed [ZW-1:0] z_up,
   input  logic                 tag_up,
   output logic signed [CW-1:0] x_dn,
   output logic signed [CW-1:0] y_dn,
   output logic signed [ZW-1:0] z_dn,
   output logic                 tag_dn
);

   localparam logic signed [ZW-1:0] ATAN_Z =
      $signed({{(ZW-pva_pkg::ATAN_W){1'b0}}, pva_pkg::ATAN_TABLE[STEP]});

   logic signed [CW-1:0] x_ff, x_in;
   logic signed [CW-1:0] y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic                 tag_ff;
   logic signed [CW-1:0] dx, dy;
   logic                 up_dir;

   // One micro-rotation. Rotation mode steers by the residual angle,
   // vectoring mode drives y toward zero.
   always_comb begin
      dx = y_up >>> STEP;
      dy = x_up >>> STEP;
      if (VECTOR) begin
         up_dir = !y_up[CW-1];
      end else begin
         up_dir = !z_up[ZW-1];
      end
      if (up_dir == !VECTOR) begin
         x_in = x_up - dx;
         y_in = y_up + dy;
      end else begin
         x_in = x_up + dx;
         y_in = y_up - dy;
      end
      if (up_dir) begin
         z_in = VECTOR ? z_up + ATAN_Z : z_up - ATAN_Z;
      end else begin
         z_in = VECTOR ? z_up - ATAN_Z : z_up + ATAN_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= tag_up;
      end
   end

   assign x_dn   = x_ff;
   assign y_dn   = y_ff;
   assign z_dn   = z_ff;
   assign tag_dn = tag_ff;

endmodule

FILE: src/pva_front.sv
module pva_front #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int ZW              = 35
) (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic        [pva_pkg::RADIUS_W-1:0]  radius,
   input  logic signed [pva_pkg::ANGLE_W-1:0]   angle,
   output logic signed [pva_pkg::RW-1:0]        x_dn,
   output logic signed [ZW-1:0]                 z_dn,
   output logic                                 flip_dn
);

   localparam int SHIFT  = pva_pkg::INT_ANGLE_BITS - ANGLE_FRAC_BITS;
   localparam int PROD_W = pva_pkg::RADIUS_W + pva_pkg::GUARD_BITS + pva_pkg::GAIN_W;
   localparam logic [PROD_W-1:0] ROUND_HALF =
      PROD_W'(1) << (pva_pkg::INT_ANGLE_BITS - 1);
   localparam logic signed [ZW-1:0] PI_Z =
      $signed({{(ZW-pva_pkg::ATAN_W){1'b0}}, pva_pkg::PI_Q30});
   localparam logic signed [ZW-1:0] HALF_PI_Z =
      $signed({{(ZW-pva_pkg::ATAN_W){1'b0}}, pva_pkg::HALF_PI_Q30});

   logic        [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ZW-1:0]          z1_ff, z1_in;
   logic                          flip1_ff, flip1_in;
   logic signed [ZW-1:0]          z_raw;
   logic        [PROD_W-1:0]      prod_round;
   logic signed [pva_pkg::RW-1:0] x_ff, x_in;
   logic signed [ZW-1:0]          z2_ff;
   logic                          flip2_ff;

   // Stage one: remove the CORDIC gain from the radius and fold the angle
   // into plus or minus pi/2, remembering the half turn.
   always_comb begin
      prod_in = PROD_W'({radius, {pva_pkg::GUARD_BITS{1'b0}}}) *
                PROD_W'(pva_pkg::GAIN_Q30);
      z_raw   = $signed({{(ZW-pva_pkg::ANGLE_W){angle[pva_pkg::ANGLE_W-1]}}, angle}) <<< SHIFT;
      if (z_raw > HALF_PI_Z) begin
         z1_in    = z_raw - PI_Z;
         flip1_in = 1'b1;
      end else if (z_raw < -HALF_PI_Z) begin
         z1_in    = z_raw + PI_Z;
         flip1_in = 1'b1;
      end else begin
         z1_in    = z_raw;
         flip1_in = 1'b0;
      end
   end

   // Stage two: round the scaled radius into the starting x coordinate.
   always_comb begin
      prod_round = (prod_ff + ROUND_HALF) >> pva_pkg::INT_ANGLE_BITS;
      x_in       = $signed(prod_round[pva_pkg::RW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         z1_ff    <= z1_in;
         flip1_ff <= flip1_in;
         x_ff     <= x_in;
         z2_ff    <= z1_ff;
         flip2_ff <= flip1_ff;
      end
   end

   assign x_dn    = x_ff;
   assign z_dn    = z2_ff;
   assign flip_dn = flip2_ff;

endmodule

FILE: src/pva_combine.sv
module pva_combine (
   input  logic                            clock,
   input  logic                            advance,
   input  logic signed [pva_pkg::RW-1:0]   xa,
   input  logic signed [pva_pkg::RW-1:0]   ya,
   input  logic                            flip_a,
   input  logic signed [pva_pkg::RW-1:0]   xb,
   input  logic signed [pva_pkg::RW-1:0]   yb,
   input  logic                            flip_b,
   output logic signed [pva_pkg::VW-1:0]   x_dn,
   output logic signed [pva_pkg::VW-1:0]   y_dn,
   output logic signed [pva_pkg::ZV_W-1:0] z_dn,
   output logic                            zero_dn
);

   localparam int VW = pva_pkg::VW;
   localparam int RW = pva_pkg::RW;
   localparam int ZW = pva_pkg::ZV_W;
   localparam logic signed [ZW-1:0] PI_Z =
      $signed({{(ZW-pva_pkg::ATAN_W){1'b0}}, pva_pkg::PI_Q30});

   logic signed [VW-1:0] xa_e, ya_e, xb_e, yb_e;
   logic signed [VW-1:0] xs_ff, xs_in;
   logic signed [VW-1:0] ys_ff, ys_in;
   logic signed [VW-1:0] x_ff, x_in;
   logic signed [VW-1:0] y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic                 zero_ff, zero_in;

   // Stage one: undo the half turn of each point and add the coordinates.
   always_comb begin
      xa_e  = $signed({{(VW-RW){xa[RW-1]}}, xa});
      ya_e  = $signed({{(VW-RW){ya[RW-1]}}, ya});
      xb_e  = $signed({{(VW-RW){xb[RW-1]}}, xb});
      yb_e  = $signed({{(VW-RW){yb[RW-1]}}, yb});
      xs_in = (flip_a ? -xa_e : xa_e) + (flip_b ? -xb_e : xb_e);
      ys_in = (flip_a ? -ya_e : ya_e) + (flip_b ? -yb_e : yb_e);
   end

   // Stage two: move a sum in the left half plane to the right half plane,
   // starting the angle at plus or minus pi, and flag a zero sum.
   always_comb begin
      zero_in = (xs_ff == '0) && (ys_ff == '0);
      if (xs_ff[VW-1]) begin
         x_in = -xs_ff;
         y_in = -ys_ff;
         z_in = ys_ff[VW-1] ? -PI_Z : PI_Z;
      end else begin
         x_in = xs_ff;
         y_in = ys_ff;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xs_ff   <= xs_in;
         ys_ff   <= ys_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         zero_ff <= zero_in;
      end
   end

   assign x_dn    = x_ff;
   assign y_dn    = y_ff;
   assign z_dn    = z_ff;
   assign zero_dn = zero_ff;

endmodule

FILE: src/pva_finish.sv
module pva_finish #(
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [pva_pkg::VW-1:0]     x_up,
   input  logic signed [pva_pkg::ZV_W-1:0]   z_up,
   input  logic                              zero_up,
   output logic        [pva_pkg::RSUM_W-1:0] radius_sum,
   output logic signed [pva_pkg::ANGLE_W-1:0] angle_sum
);

   localparam int VW        = pva_pkg::VW;
   localparam int ZW        = pva_pkg::ZV_W;
   localparam int PW        = VW + pva_pkg::GAIN_W + 1;
   localparam int SHIFT     = pva_pkg::INT_ANGLE_BITS - ANGLE_FRAC_BITS;
   localparam int MAG_SHIFT = pva_pkg::INT_ANGLE_BITS + pva_pkg::GUARD_BITS;
   localparam logic signed [ZW-1:0] Z_HALF = ZW'(1) <<< (SHIFT - 1);
   localparam logic signed [PW-1:0] M_HALF = PW'(1) <<< (MAG_SHIFT - 1);
   localparam logic signed [PW-1:0] RADIUS_MAX = PW'((1 << pva_pkg::RSUM_W) - 1);
   localparam logic signed [ZW-1:0] PI_OUT =
      $signed(ZW'(({2'b00, pva_pkg::PI_Q30} + (34'd1 << (SHIFT - 1))) >> SHIFT));

   logic signed [PW-1:0]                 prod_ff, prod_in;
   logic signed [ZW-1:0]                 ang_ff, ang_in;
   logic                                 zero_ff;
   logic signed [PW-1:0]                 mag;
   logic signed [ZW-1:0]                 ang_c;
   logic        [pva_pkg::RSUM_W-1:0]    radius_ff, radius_in;
   logic signed [pva_pkg::ANGLE_W-1:0]   angle_ff, angle_in;

   // Stage one: gain correction of the magnitude and rounding of the angle.
   always_comb begin
      prod_in = $signed({{(PW-VW){x_up[VW-1]}}, x_up}) *
                $signed({{(PW-pva_pkg::GAIN_W){1'b0}}, pva_pkg::GAIN_Q30});
      ang_in  = (z_up + Z_HALF) >>> SHIFT;
   end

   // Stage two: round and clamp the magnitude, clamp the angle to (-pi, pi], and zero both for a zero sum.
   always_comb begin
      mag = (prod_ff + M_HALF) >>> MAG_SHIFT;
      if (mag[PW-1]) begin
         mag = '0;
      end else if (mag > RADIUS_MAX) begin
         mag = RADIUS_MAX;
      end
      ang_c = ang_ff;
      if (ang_c > PI_OUT) begin
         ang_c = PI_OUT;
      end
      if (ang_c <= -PI_OUT) begin
         ang_c = PI_OUT;
      end
      if (zero_ff) begin
         radius_in = '0;
         angle_in  = '0;
      end else begin
         radius_in = mag[pva_pkg::RSUM_W-1:0];
         angle_in  = ang_c[pva_pkg::ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         ang_ff    <= ang_in;
         zero_ff   <= zero_up;
         radius_ff <= radius_in;
         angle_ff  <= angle_in;
      end
   end

   assign radius_sum = radius_ff;
   assign angle_sum  = angle_ff;

endmodule

FILE: src/polar_vector_adder_unit.sv
// A request reaches the response through the unrolled rotation and vectoring
// CORDIC stages, one per step (16 steps by default), plus two front, two
// combine and two output stages.
// Throughput: one transaction per cycle; the whole pipeline holds while a
// finished response waits at the output register.
// Reset clears only the stage valid bits; the datapath needs no clearing.
module polar_vector_adder_unit #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic      clock,
   input  logic      reset,
   pva_req_if.sink   req_ch,
   pva_rsp_if.source rsp_ch
);

   localparam int RW   = pva_pkg::RW;
   localparam int VW   = pva_pkg::VW;
   localparam int ZV_W = pva_pkg::ZV_W;
   localparam int ZR_W = (48 - ANGLE_FRAC_BITS > 34) ? 48 - ANGLE_FRAC_BITS : 34;
   localparam int LAT  = 2 * CORDIC_STEPS + 6;

   logic             advance;
   logic [LAT-1:0]   valid_ff, valid_in;

   logic signed [RW-1:0]   rax [CORDIC_STEPS+1];
   logic signed [RW-1:0]   ray [CORDIC_STEPS+1];
   logic signed [ZR_W-1:0] raz [CORDIC_STEPS+1];
   logic                   raf [CORDIC_STEPS+1];
   logic signed [RW-1:0]   rbx [CORDIC_STEPS+1];
   logic signed [RW-1:0]   rby [CORDIC_STEPS+1];
   logic signed [ZR_W-1:0] rbz [CORDIC_STEPS+1];
   logic                   rbf [CORDIC_STEPS+1];

   logic signed [VW-1:0]   vx [CORDIC_STEPS+1];
   logic signed [VW-1:0]   vy [CORDIC_STEPS+1];
   logic signed [ZV_W-1:0] vz [CORDIC_STEPS+1];
   logic                   vzero [CORDIC_STEPS+1];

   // The pipeline moves whenever the output register is empty or being taken.
   assign advance      = !valid_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign rsp_ch.valid = valid_ff[LAT-1];

   // Valid bits travel alongside the data.
   assign valid_in = {valid_ff[LAT-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Gain removal and quadrant folding for each point.
   pva_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .ZW(ZR_W)) u_front_a (
      .clock   (clock),
      .advance (advance),
      .radius  (req_ch.radius_a),
      .angle   (req_ch.angle_a),
      .x_dn    (rax[0]),
      .z_dn    (raz[0]),
      .flip_dn (raf[0])
   );

   pva_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .ZW(ZR_W)) u_front_b (
      .clock   (clock),
      .advance (advance),
      .radius  (req_ch.radius_b),
      .angle   (req_ch.angle_b),
      .x_dn    (rbx[0]),
      .z_dn    (rbz[0]),
      .flip_dn (rbf[0])
   );

   assign ray[0] = '0;
   assign rby[0] = '0;

   // Rotation-mode CORDIC, one stage per step, for both points side by side.
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      pva_cordic_stage #(.STEP(k), .CW(RW), .ZW(ZR_W), .VECTOR(1'b0)) u_rot_a (
         .clock   (clock),
         .advance (advance),
         .x_up    (rax[k]),
         .y_up    (ray[k]),
         .z_up    (raz[k]),
         .tag_up  (raf[k]),
         .x_dn    (rax[k+1]),
         .y_dn    (ray[k+1]),
         .z_dn    (raz[k+1]),
         .tag_dn  (raf[k+1])
      );

      pva_cordic_stage #(.STEP(k), .CW(RW), .ZW(ZR_W), .VECTOR(1'b0)) u_rot_b (
         .clock   (clock),
         .advance (advance),
         .x_up    (rbx[k]),
         .y_up    (rby[k]),
         .z_up    (rbz[k]),
         .tag_up  (rbf[k]),
         .x_dn    (rbx[k+1]),
         .y_dn    (rby[k+1]),
         .z_dn    (rbz[k+1]),
         .tag_dn  (rbf[k+1])
      );
   end

   // Rectangular sum and setup for vectoring.
   pva_combine u_combine (
      .clock   (clock),
      .advance (advance),
      .xa      (rax[CORDIC_STEPS]),
      .ya      (ray[CORDIC_STEPS]),
      .flip_a  (raf[CORDIC_STEPS]),
      .xb      (rbx[CORDIC_STEPS]),
      .yb      (rby[CORDIC_STEPS]),
      .flip_b  (rbf[CORDIC_STEPS]),
      .x_dn    (vx[0]),
      .y_dn    (vy[0]),
      .z_dn    (vz[0]),
      .zero_dn (vzero[0])
   );

   // Vectoring-mode CORDIC; the zero-sum flag rides along as the tag.
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
      pva_cordic_stage #(.STEP(k), .CW(VW), .ZW(ZV_W), .VECTOR(1'b1)) u_vec (
         .clock   (clock),
         .advance (advance),
         .x_up    (vx[k]),
         .y_up    (vy[k]),
         .z_up    (vz[k]),
         .tag_up  (vzero[k]),
         .x_dn    (vx[k+1]),
         .y_dn    (vy[k+1]),
         .z_dn    (vz[k+1]),
         .tag_dn  (vzero[k+1])
      );
   end

   // Magnitude gain correction, rounding and output register.
   pva_finish #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_finish (
      .clock      (clock),
      .advance    (advance),
      .x_up       (vx[CORDIC_STEPS]),
      .z_up       (vz[CORDIC_STEPS]),
      .zero_up    (vzero[CORDIC_STEPS]),
      .radius_sum (rsp_ch.radius_sum),
      .angle_sum  (rsp_ch.angle_sum)
   );

endmodule
